FILE: hdl/mpc_pkg.sv
// ----------------------------------------------------------------------------
// mpc_pkg: shared definitions for the max piece count block
// Sizes of the fields and the length table, the table entry layout and the
// sequencer states.
// ----------------------------------------------------------------------------
package mpc_pkg;

	localparam int MAX_LEN   = 4096;
	localparam int LEN_W     = 13;
	localparam int CNT_W     = 13;
	localparam int ENTRY_W   = CNT_W + 1;
	localparam int TBL_DEPTH = MAX_LEN + 1;
	localparam int ADDR_W    = $clog2(TBL_DEPTH);

	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;

	localparam cnt_t COUNT_MAX = {CNT_W{1'b1}};

	typedef struct packed {
		logic valid;
		cnt_t count;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT,
		S_RD_A,
		S_RD_B,
		S_RD_C,
		S_WR,
		S_DONE
	} state_t;

endpackage

FILE: hdl/mpc_ram.sv
// ----------------------------------------------------------------------------
// mpc_ram: generic single write port, single read port RAM
// Synchronous write and registered read; read data appears in the cycle after
// the read address is presented.
// ----------------------------------------------------------------------------
module mpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: hdl/max_piece_count_dp_core.sv
// ----------------------------------------------------------------------------
// max_piece_count_dp_core: largest exact cut into three piece lengths
// Fills a table of best piece counts for every length from zero up to the
// target, one length after another, with one compare and increment unit.
//
//   channel | direction | beat contents
//   in      | sink      | target_length, piece_a, piece_b, piece_c
//   out     | source    | max_pieces, reachable
//
// Each length needs three lookback reads through the single table read port
// and one write, in states S_RD_A, S_RD_B, S_RD_C and S_WR. A target above
// the table size skips the sweep and goes straight to S_DONE.
// Reset clears the sequencer and the output valid; the table needs no
// clearing because every entry is written before it is read.
// A new beat is accepted as soon as the previous result sits in the output
// register, even while out_ready is low.
// ----------------------------------------------------------------------------
module max_piece_count_dp_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mpc_pkg::len_t      target_length,
	input  mpc_pkg::len_t      piece_a,
	input  mpc_pkg::len_t      piece_b,
	input  mpc_pkg::len_t      piece_c,
	output logic               out_valid,
	input  logic               out_ready,
	output mpc_pkg::cnt_t      max_pieces,
	output logic               reachable
);

	import mpc_pkg::*;

	state_t state_q, state_nx;

	len_t   target_q, pa_q, pb_q, pc_q, len_q;
	logic   ok_q, any_q;
	cnt_t   best_q;
	entry_t last_q;
	logic   out_valid_q, reachable_q;
	cnt_t   max_pieces_q;

	logic   wr_en, rd_en;
	addr_t  wr_addr, rd_addr;
	entry_t wr_entry, rd_entry;
	logic [ENTRY_W-1:0] rd_data;

	len_t   piece_sel;
	logic   applies;
	cnt_t   cand, best_nx;
	logic   take, any_nx, load_out;

	mpc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TBL_DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_entry),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Shared unit: folds the lookback that arrives from the table into the best count.
	always_comb begin
		rd_entry = entry_t'(rd_data);
		cand     = (rd_entry.count == COUNT_MAX) ? COUNT_MAX : rd_entry.count + 1'b1;
		take     = ok_q && rd_entry.valid && (!any_q || cand > best_q);
		any_nx   = any_q || (ok_q && rd_entry.valid);
		best_nx  = take ? cand : best_q;
	end

	always_comb begin
		state_nx  = state_q;
		in_ready  = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_entry  = '0;
		piece_sel = pa_q;
		rd_en     = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_nx = (32'(target_length) > MAX_LEN) ? S_DONE : S_INIT;
				end
			end
			S_INIT: begin
				wr_en          = 1'b1;
				wr_entry.valid = 1'b1;
				state_nx       = (target_q == '0) ? S_DONE : S_RD_A;
			end
			S_RD_A: begin
				piece_sel = pa_q;
				rd_en     = applies;
				state_nx  = S_RD_B;
			end
			S_RD_B: begin
				piece_sel = pb_q;
				rd_en     = applies;
				state_nx  = S_RD_C;
			end
			S_RD_C: begin
				piece_sel = pc_q;
				rd_en     = applies;
				state_nx  = S_WR;
			end
			S_WR: begin
				wr_en          = 1'b1;
				wr_addr        = ADDR_W'(len_q);
				wr_entry.valid = any_nx;
				wr_entry.count = any_nx ? best_nx : '0;
				state_nx       = (len_q == target_q) ? S_DONE : S_RD_A;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	assign applies = (piece_sel != '0) && (piece_sel <= len_q);
	assign rd_addr = ADDR_W'(len_q - piece_sel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ok_q <= rd_en;
		case (state_q)
			S_IDLE: begin
				target_q <= target_length;
				pa_q     <= piece_a;
				pb_q     <= piece_b;
				pc_q     <= piece_c;
				len_q    <= len_t'(1);
				last_q   <= '0;
			end
			S_INIT: begin
				last_q.valid <= 1'b1;
				last_q.count <= '0;
			end
			S_RD_A: begin
				any_q  <= 1'b0;
				best_q <= '0;
			end
			S_RD_B, S_RD_C: begin
				any_q  <= any_nx;
				best_q <= best_nx;
			end
			S_WR: begin
				last_q <= wr_entry;
				len_q  <= len_q + 1'b1;
			end
			S_DONE: begin
				if (load_out) begin
					reachable_q  <= last_q.valid;
					max_pieces_q <= last_q.count;
				end
			end
			default: begin
				last_q <= last_q;
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign max_pieces = max_pieces_q;
	assign reachable  = reachable_q;

endmodule

FILE: tb/tb_max_piece_count_dp_core.sv
// ----------------------------------------------------------------------------
// tb_max_piece_count_dp_core: testbench for the exact cut piece maximizer
// Sends target and piece lengths through the input handshake and predicts
// each beat's best exact piece count with an independent length table
// sweep. Every output beat is compared in order with its prediction.
// Corner lengths, back to back traffic, random traffic with idle gaps and
// a few long targets are covered.
// ----------------------------------------------------------------------------
module tb_max_piece_count_dp_core;
	timeunit 1ns;
	timeprecision 1ps;
	import mpc_pkg::*;

	localparam int IDLE_MAX    = 11;
	localparam int FIELD_MAX   = (1 << LEN_W) - 1;
	localparam int STALL_LIMIT = 4 * (4 * MAX_LEN + 3 + 2 * IDLE_MAX);

	typedef struct packed {
		len_t tgt;
		cnt_t pieces;
		logic reach;
	} cut_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	len_t target_length = '0;
	len_t piece_a = '0;
	len_t piece_b = '0;
	len_t piece_c = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	cnt_t max_pieces;
	logic reachable;

	cut_t   pending_cuts[$];
	entry_t cut_tbl [0:MAX_LEN];
	int     mismatches = 0;
	int     cuts_sent = 0;
	int     cuts_checked = 0;
	int     cuts_reachable = 0;
	int     cuts_oversize = 0;
	int     longest_target = 0;
	int     rx_stall = 0;
	int     stall_draw;
	int     idle_cycles = 0;
	bit     no_idle = 1'b0;

	max_piece_count_dp_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.target_length (target_length),
		.piece_a       (piece_a),
		.piece_b       (piece_b),
		.piece_c       (piece_c),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.max_pieces    (max_pieces),
		.reachable     (reachable)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic cut_t best_cut(len_t tgt, len_t a, len_t b, len_t c);
		cut_t res;
		len_t pcs [3];
		int   best;
		int   cand;
		bit   any;
		res = '0;
		res.tgt = tgt;
		pcs[0] = a;
		pcs[1] = b;
		pcs[2] = c;
		if (tgt > MAX_LEN)
			return res;
		cut_tbl[0] = '{valid: 1'b1, count: '0};
		for (int len = 1; len <= tgt; len++) begin
			best = 0;
			any = 1'b0;
			for (int k = 0; k < 3; k++) begin
				if (pcs[k] != 0 && pcs[k] <= len && cut_tbl[len - pcs[k]].valid) begin
					cand = int'(cut_tbl[len - pcs[k]].count) + 1;
					if (cand > COUNT_MAX)
						cand = COUNT_MAX;
					if (!any || cand > best)
						best = cand;
					any = 1'b1;
				end
			end
			cut_tbl[len] = '0;
			if (any)
				cut_tbl[len] = '{valid: 1'b1, count: cnt_t'(best)};
		end
		if (cut_tbl[tgt].valid) begin
			res.pieces = cut_tbl[tgt].count;
			res.reach = 1'b1;
		end
		return res;
	endfunction

	task automatic report_mismatch(string what);
		$display("ERROR at %0t ns: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic check_cut();
		cut_t want;
		if (pending_cuts.size() == 0) begin
			report_mismatch($sformatf("result beat with no input pending: %0d/%0b",
				max_pieces, reachable));
		end else begin
			want = pending_cuts.pop_front();
			cuts_checked++;
			if (max_pieces !== want.pieces)
				report_mismatch($sformatf("target %0d: max_pieces %0d, expected %0d",
					want.tgt, max_pieces, want.pieces));
			if (reachable !== want.reach)
				report_mismatch($sformatf("target %0d: reachable %0b, expected %0b",
					want.tgt, reachable, want.reach));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_stall <= 0;
		end else if (out_valid && out_ready) begin
			check_cut();
			stall_draw = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
			rx_stall <= stall_draw;
			out_ready <= (stall_draw == 0);
		end else if (rx_stall > 1) begin
			rx_stall <= rx_stall - 1;
		end else begin
			rx_stall <= 0;
			out_ready <= 1'b1;
		end
	end

	initial begin
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
		$display("tb_max_piece_count_dp_core NOT OK");
		$finish;
	end

	task automatic send_cut(len_t tgt, len_t a, len_t b, len_t c);
		int   gap;
		cut_t want;
		gap = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		target_length <= tgt;
		piece_a <= a;
		piece_b <= b;
		piece_c <= c;
		do @(posedge clk); while (!in_ready);
		want = best_cut(tgt, a, b, c);
		pending_cuts.push_back(want);
		cuts_sent++;
		if (tgt > MAX_LEN)
			cuts_oversize++;
		else if (tgt > longest_target)
			longest_target = tgt;
		if (want.reach)
			cuts_reachable++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_cuts.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random(int tgt_max);
		len_t tgt;
		len_t pcs [3];
		int   pick;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			tgt = len_t'($urandom_range(MAX_LEN + 1, FIELD_MAX));
		else
			tgt = len_t'($urandom_range(0, tgt_max));
		for (int k = 0; k < 3; k++) begin
			pick = $urandom_range(0, 15);
			if (pick == 0)
				pcs[k] = '0;
			else if (pick == 1)
				pcs[k] = len_t'($urandom_range(0, FIELD_MAX));
			else
				pcs[k] = len_t'($urandom_range(1, 20));
		end
		send_cut(tgt, pcs[0], pcs[1], pcs[2]);
	endtask

	task automatic test_corners();
		send_cut(0, 1, 2, 3);
		send_cut(0, 0, 0, 0);
		send_cut(5, 0, 0, 0);
		send_cut(1, 1, 0, 0);
		send_cut(7, 5, 3, 2);
		send_cut(13, 4, 6, 9);
		send_cut(6, 7, 8, 13'h1FFF);
		send_cut(9, 4, 0, 6);
		send_cut(12, 0, 0, 4);
		send_cut(100, 3, 3, 3);
		send_cut(100, 7, 11, 13);
		send_cut(4096, 1, 1, 1);
		send_cut(4096, 4096, 13'h1FFF, 13'h1000);
		send_cut(4095, 2, 4096, 13'h1FFF);
		send_cut(4097, 1, 1, 1);
		send_cut(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
		send_cut(13'h1555, 13'h0AAA, 13'h1555, 1);
		send_cut(13'h0AAA, 13'h0AAA, 13'h1555, 13'h0555);
		wait_drained();
	endtask

	task automatic test_back_to_back();
		no_idle = 1'b1;
		repeat (20) send_random(60);
		wait_drained();
		no_idle = 1'b0;
	endtask

	task automatic test_random();
		for (int n = 1; n <= 96; n++) begin
			send_random(160);
			if (n % 30 == 0)
				wait_drained();
		end
	endtask

	task automatic test_long_targets();
		repeat (6) begin
			send_cut(len_t'($urandom_range(1024, MAX_LEN)), len_t'($urandom_range(1, 40)),
				len_t'($urandom_range(1, 40)), len_t'($urandom_range(0, 40)));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corners();
		test_back_to_back();
		test_random();
		test_long_targets();
		wait_drained();
		repeat (8) @(posedge clk);
		$display("Checked %0d of %0d cuts: %0d reachable, %0d beyond the table.",
			cuts_checked, cuts_sent, cuts_reachable, cuts_oversize);
		$display("Longest target swept was %0d, with %0d mismatches.",
			longest_target, mismatches);
		if (mismatches == 0)
			$display("tb_max_piece_count_dp_core OK");
		else
			$display("tb_max_piece_count_dp_core NOT OK");
		$finish;
	end

endmodule
